### hdl/gcc_pkg.sv
// ----------------------------------------------------------------------------
// gcc_pkg
// Shared widths, register codes, reset values and the request/response
// types of the divider used by the greedy coin change block.
// ----------------------------------------------------------------------------
`default_nettype none

package gcc_pkg;

  // Width of amounts, denominations and coin counts.
  localparam int DATA_W = 16;
  // Width of the register index and of the coin index on the result word.
  localparam int IDX_W = 3;
  // Width of the coins-in-use register.
  localparam int CNT_W = 3;
  // Number of denomination registers on the configuration port.
  localparam int NUM_DENOM_REGS = 5;
  // Default limit on the number of denominations the block handles.
  localparam int MAX_DENOMS_DEFAULT = 5;
  // Width of the divider step counter.
  localparam int DIV_STEP_W = $clog2(DATA_W);

  // Register index of the coins-in-use register.
  localparam logic [IDX_W-1:0] CFG_COINS_IN_USE = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [DATA_W-1:0] DENOM_RESET [NUM_DENOM_REGS] =
    '{16'd1, 16'd5, 16'd10, 16'd25, 16'd50};
  localparam logic [CNT_W-1:0] COINS_IN_USE_RESET = 3'd5;

  // Request to the shared divider.
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } gcc_div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
    logic [DATA_W-1:0] remainder;
  } gcc_div_rsp_t;

endpackage

`default_nettype wire

### hdl/gcc_if.sv
// ----------------------------------------------------------------------------
// gcc_in_if / gcc_out_if
// Valid/ready channels of the greedy coin change block: the amount word
// going in and the per-denomination result word coming out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcc_in_if import gcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink (input valid, input amount, output ready);
endinterface

interface gcc_out_if import gcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  coin_index;
  logic [DATA_W-1:0] coin_count;
  logic [DATA_W-1:0] total_coins;
  logic [DATA_W-1:0] remainder;
  logic              last;

  modport source (output valid, output coin_index, output coin_count,
                  output total_coins, output remainder, output last,
                  input ready);
  modport sink (input valid, input coin_index, input coin_count,
                input total_coins, input remainder, input last,
                output ready);
endinterface

`default_nettype wire

### hdl/gcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// gcc_cfg_regs
// Configuration register file: the denomination values and the number of
// denominations in use, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_cfg_regs import gcc_pkg::*; #(
  parameter int NUM_DENOMS = MAX_DENOMS_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_we,
  input  wire logic [IDX_W-1:0]                     cfg_index,
  input  wire logic [DATA_W-1:0]                    cfg_data,
  output logic      [NUM_DENOMS-1:0][DATA_W-1:0]    denom,
  output logic      [CNT_W-1:0]                     coins_in_use
);

  // Only the denominations the block can ever use are stored; writes to
  // the others are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        denom[i] <= DENOM_RESET[i];
      end
      coins_in_use <= COINS_IN_USE_RESET;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_DENOMS; i++) begin
        if (cfg_index == IDX_W'(i)) begin
          denom[i] <= cfg_data;
        end
      end
      if (cfg_index == CFG_COINS_IN_USE) begin
        coins_in_use <= cfg_data[CNT_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

### hdl/gcc_divider.sv
// ----------------------------------------------------------------------------
// gcc_divider
// Restoring divider, one quotient bit per cycle. A start request loads the
// operands; the quotient and remainder are valid with the done pulse.
// ----------------------------------------------------------------------------
`default_nettype none

module gcc_divider import gcc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire gcc_div_req_t req,
  output gcc_div_rsp_t      rsp
);

  logic                  busy;
  logic                  done;
  logic [DIV_STEP_W-1:0] step;
  logic [DATA_W-1:0]     rem;
  logic [DATA_W-1:0]     quo;
  logic [DATA_W-1:0]     divisor;
  logic [DATA_W+1:0]     trial;

  // Shift the next dividend bit into the partial remainder and try to
  // subtract the divisor; a negative result means the bit is zero.
  assign trial = {1'b0, rem, quo[DATA_W-1]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        step    <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (busy) begin
        if (trial[DATA_W+1]) begin
          rem <= {rem[DATA_W-2:0], quo[DATA_W-1]};
          quo <= {quo[DATA_W-2:0], 1'b0};
        end else begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end
        step <= step + DIV_STEP_W'(1);
        if (step == DIV_STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quotient: quo, remainder: rem};

endmodule

`default_nettype wire

### hdl/greedy_coin_change.sv
// ----------------------------------------------------------------------------
// greedy_coin_change
// Greedy split of an amount over the configured coin denominations.
// ----------------------------------------------------------------------------
// An amount word is taken when the block is idle; it then emits one result
// word per denomination in use, largest index first, with the coin count,
// the running coin total and the amount still unpaid, and flags the word
// for denomination 0 as last. No new amount is taken until the last result
// word has been taken. Each denomination passes through a setup state,
// the 16-step restoring divider with its done pulse and an output state;
// a denomination of zero skips the divider. All denominations share the
// single divider. Denominations must be written while the block is idle;
// coins_in_use of zero acts as one.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_coin_change import gcc_pkg::*; #(
  parameter int MAX_DENOMS = MAX_DENOMS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  gcc_in_if.sink                 amount_ch,
  gcc_out_if.source              coin_ch
);

  localparam int NumActive = (MAX_DENOMS < NUM_DENOM_REGS) ? MAX_DENOMS : NUM_DENOM_REGS;
  localparam int SelW      = (NumActive > 1) ? $clog2(NumActive) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  state_t                           state;
  logic [NumActive-1:0][DATA_W-1:0] denom;
  logic [CNT_W-1:0]                 coins_in_use;
  logic [CNT_W-1:0]                 n_active;
  logic [CNT_W-1:0]                 n_minus;
  logic [SelW-1:0]                  sel;
  logic [DATA_W-1:0]                rest;
  logic [DATA_W-1:0]                total;
  logic [DATA_W-1:0]                count;
  logic [DATA_W-1:0]                cur_denom;
  logic                             denom_zero;
  gcc_div_req_t                     div_req;
  gcc_div_rsp_t                     div_rsp;

  gcc_cfg_regs #(
    .NUM_DENOMS (NumActive)
  ) u_cfg_regs (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .denom        (denom),
    .coins_in_use (coins_in_use)
  );

  gcc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Number of denominations in use, clamped to one and to the stored count.
  always_comb begin
    priority if (coins_in_use == '0) begin
      n_active = CNT_W'(1);
    end else if (coins_in_use > CNT_W'(NumActive)) begin
      n_active = CNT_W'(NumActive);
    end else begin
      n_active = coins_in_use;
    end
    n_minus = n_active - CNT_W'(1);
  end

  // Denomination under work; a zero value pays nothing and skips the divider.
  assign cur_denom  = denom[sel];
  assign denom_zero = (cur_denom == '0);

  assign div_req = '{start:    (state == S_START) && !denom_zero,
                     dividend: rest,
                     divisor:  cur_denom};

  // Sequencer: one division per nonzero denomination, one result word after each.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (amount_ch.valid) begin
            rest  <= amount_ch.amount;
            total <= '0;
            sel   <= n_minus[SelW-1:0];
            state <= S_START;
          end
        end
        S_START: begin
          if (denom_zero) begin
            count <= '0;
            state <= S_OUT;
          end else begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            count <= div_rsp.quotient;
            rest  <= div_rsp.remainder;
            total <= total + div_rsp.quotient;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (coin_ch.ready) begin
            if (sel == '0) begin
              state <= S_IDLE;
            end else begin
              sel   <= sel - SelW'(1);
              state <= S_START;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Handshake and result word.
  assign amount_ch.ready     = (state == S_IDLE);
  assign coin_ch.valid       = (state == S_OUT);
  assign coin_ch.coin_index  = IDX_W'(sel);
  assign coin_ch.coin_count  = count;
  assign coin_ch.total_coins = total;
  assign coin_ch.remainder   = rest;
  assign coin_ch.last        = (sel == '0);

endmodule

`default_nettype wire

### dv/tb_greedy_coin_change.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_greedy_coin_change
// Self-checking testbench of the greedy coin change block. An amount word
// goes in on one valid/ready channel. For every accepted amount the bench
// works out the per-denomination result words from its own copy of the
// denomination registers and queues them. Each result word taken from the
// block is then checked against the oldest queued word. Directed tests
// cover the reset values, register extremes, zero and unsorted
// denominations and out-of-range coin counts. A long random test follows,
// in phases with a fresh register setting each, and random stalls on both
// channels.
// ----------------------------------------------------------------------------

module tb_greedy_coin_change;
  import gcc_pkg::*;

  localparam int MAX_DENOMS = MAX_DENOMS_DEFAULT;
  localparam int ACTIVE_LIMIT =
    (MAX_DENOMS < NUM_DENOM_REGS) ? MAX_DENOMS : NUM_DENOM_REGS;
  localparam int LAST_INDEX = (1 << IDX_W) - 1;
  localparam int TAIL_CYCLES = 120;
  localparam int RANDOM_PHASES = 12;
  localparam int AMOUNTS_PER_PHASE = 37;
  localparam int REPORT_LIMIT = 10;

  // One result word as the block emits it.
  typedef struct packed {
    logic [IDX_W-1:0]  coin_index;
    logic [DATA_W-1:0] coin_count;
    logic [DATA_W-1:0] total_coins;
    logic [DATA_W-1:0] remainder;
    logic              last;
  } coin_word_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  gcc_in_if  amount_if ();
  gcc_out_if coin_if ();

  greedy_coin_change #(
    .MAX_DENOMS(MAX_DENOMS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .amount_ch(amount_if),
    .coin_ch(coin_if)
  );

  // Shadow copy of the registers and the words still owed by the block.
  logic [DATA_W-1:0] denom_shadow [NUM_DENOM_REGS];
  logic [CNT_W-1:0]  coins_shadow;
  coin_word_t        owed_words [$];
  int                mismatch_count;
  bit                send_idle;
  bit                take_idle;
  coin_word_t        want_word;
  coin_word_t        got_word;

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Random gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit enable);
    int r;
    if (!enable) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Greedy split of one amount under the shadow registers; the result words
  // are appended to the queue of owed words, highest denomination index first.
  function automatic void split_amount(input logic [DATA_W-1:0] amount);
    int unsigned rest;
    int unsigned total;
    int unsigned cnt;
    int unsigned d;
    int          n;
    int          idx;
    coin_word_t  w;
    rest  = amount;
    total = 0;
    n     = coins_shadow;
    if (n == 0) n = 1;
    if (n > ACTIVE_LIMIT) n = ACTIVE_LIMIT;
    for (idx = n - 1; idx >= 0; idx--) begin
      d   = denom_shadow[idx];
      cnt = 0;
      // A zero coin pays nothing and leaves the rest as it is.
      if (d != 0) begin
        cnt  = rest / d;
        rest = rest % d;
      end
      total         += cnt;
      w.coin_index   = idx[IDX_W-1:0];
      w.coin_count   = cnt[DATA_W-1:0];
      w.total_coins  = total[DATA_W-1:0];
      w.remainder    = rest[DATA_W-1:0];
      w.last         = (idx == 0);
      owed_words.push_back(w);
    end
  endfunction

  // Send one amount word after a random gap; valid stays high afterward so
  // that a following word can go out back to back.
  task automatic send_amount(input logic [DATA_W-1:0] amount);
    int gap;
    gap = pick_gap(send_idle);
    if (gap > 0) begin
      amount_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    amount_if.valid  <= 1'b1;
    amount_if.amount <= amount;
    do @(posedge clk); while (!amount_if.ready);
    split_amount(amount);
  endtask

  // Drop valid and wait until every owed word has come back.
  task automatic drain_results();
    amount_if.valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
  endtask

  // Write all six registers, optionally poke the unused indexes too.
  task automatic load_config(input logic [DATA_W-1:0] d0, input logic [DATA_W-1:0] d1,
                             input logic [DATA_W-1:0] d2, input logic [DATA_W-1:0] d3,
                             input logic [DATA_W-1:0] d4,
                             input logic [DATA_W-1:0] coins_data, input bit poke_spare);
    logic [DATA_W-1:0] vals [NUM_DENOM_REGS+1];
    int                i;
    vals[0] = d0;
    vals[1] = d1;
    vals[2] = d2;
    vals[3] = d3;
    vals[4] = d4;
    vals[CFG_COINS_IN_USE] = coins_data;
    for (i = 0; i <= CFG_COINS_IN_USE; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[IDX_W-1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      if (i < NUM_DENOM_REGS) begin
        denom_shadow[i] = vals[i];
      end else if (i == CFG_COINS_IN_USE) begin
        coins_shadow = vals[i][CNT_W-1:0];
      end
    end
    // Indexes past the last register are expected to change nothing.
    if (poke_spare) begin
      for (i = CFG_COINS_IN_USE + 1; i <= LAST_INDEX; i++) begin
        cfg_we    <= 1'b1;
        cfg_index <= i[IDX_W-1:0];
        cfg_data  <= DATA_W'($urandom_range(0, 65535));
        @(posedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Record a failed check; only the first few are printed.
  task automatic note_mismatch(input string what, input coin_word_t want,
                               input coin_word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t: %s: expected idx=%0d cnt=%0d total=%0d rem=%0d last=%0b",
               $realtime, what, want.coin_index, want.coin_count, want.total_coins,
               want.remainder, want.last);
      $display("%0t: %s:   actual idx=%0d cnt=%0d total=%0d rem=%0d last=%0b",
               $realtime, what, got.coin_index, got.coin_count, got.total_coins,
               got.remainder, got.last);
    end
  endtask

  // Result side: check each word taken against the oldest owed word.
  always @(posedge clk) begin
    if (!rst && coin_if.valid && coin_if.ready) begin
      got_word.coin_index  = coin_if.coin_index;
      got_word.coin_count  = coin_if.coin_count;
      got_word.total_coins = coin_if.total_coins;
      got_word.remainder   = coin_if.remainder;
      got_word.last        = coin_if.last;
      if (owed_words.size() == 0) begin
        want_word = '0;
        note_mismatch("unexpected word", want_word, got_word);
      end else begin
        want_word = owed_words.pop_front();
        if (got_word.coin_index !== want_word.coin_index ||
            got_word.coin_count !== want_word.coin_count ||
            got_word.total_coins !== want_word.total_coins ||
            got_word.remainder !== want_word.remainder ||
            got_word.last !== want_word.last) begin
          note_mismatch("word mismatch", want_word, got_word);
        end
      end
    end
  end

  // Result side: ready in random bursts separated by random stalls.
  initial begin
    int gap;
    coin_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap(take_idle);
      if (gap > 0) begin
        coin_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      coin_if.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Reset values: the stock 1, 5, 10, 25, 50 set with all five in use.
  task automatic test_reset_values();
    send_amount(16'd0);
    send_amount(16'd65535);
    send_amount(16'd1);
    send_amount(16'd4);
    send_amount(16'd5);
    send_amount(16'd99);
    send_amount(16'd41);
    send_amount(16'd30);
  endtask

  // Register extremes and the corner cases of the split.
  task automatic test_register_extremes();
    // Largest coins everywhere.
    drain_results();
    load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd5, 1'b0);
    send_amount(16'd65535);
    send_amount(16'd65534);
    send_amount(16'd0);
    // One coin of value 1 pays the largest amount; upper data bits set.
    drain_results();
    load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'hFFF9, 1'b1);
    send_amount(16'd65535);
    // A coin count of zero acts as one.
    drain_results();
    load_config(16'd1, 16'd5, 16'd10, 16'd25, 16'd50, 16'd0, 1'b0);
    send_amount(16'd37);
    // A coin count above the limit saturates.
    drain_results();
    load_config(16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd7, 1'b1);
    send_amount(16'd65535);
    send_amount(16'd1);
    // Zero denominations pay nothing; a count of six saturates as well.
    drain_results();
    load_config(16'd0, 16'd3, 16'd0, 16'd7, 16'd0, 16'd6, 1'b0);
    send_amount(16'd100);
    send_amount(16'd0);
    // Descending values are still taken from the highest index down.
    drain_results();
    load_config(16'd50, 16'd25, 16'd10, 16'd5, 16'd1, 16'd5, 1'b0);
    send_amount(16'd99);
    // Even coins leave an odd rest unpaid.
    drain_results();
    load_config(16'd4, 16'd6, 16'd8, 16'd10, 16'd12, 16'd5, 1'b0);
    send_amount(16'd65535);
    send_amount(16'd13);
  endtask

  // Random amounts under a series of random register settings.
  task automatic test_random_splits();
    int                v [NUM_DENOM_REGS];
    int                phase;
    int                item;
    int                i;
    int                j;
    int                t;
    int                style;
    int                r;
    logic [DATA_W-1:0] coins_data;
    logic [DATA_W-1:0] amount;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      style = $urandom_range(0, 3);
      for (i = 0; i < NUM_DENOM_REGS; i++) begin
        case (style)
          0: begin
            // Realistic ascending coin set.
            v[i] = (i == 0) ? $urandom_range(1, 5) : v[i-1] + $urandom_range(1, 40);
          end
          1: begin
            v[i] = $urandom_range(1, 65535);
          end
          2: begin
            // Unsorted, with zero coins now and then.
            v[i] = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535);
          end
          default: begin
            r = $urandom_range(0, 2);
            v[i] = (r == 0) ? 1 : (r == 1) ? 65535 : $urandom_range(1, 7);
          end
        endcase
      end
      // Most sets are sorted ascending, as software is meant to write them.
      if (style == 1 || (style == 3 && $urandom_range(0, 1) == 1)) begin
        for (i = 0; i < NUM_DENOM_REGS - 1; i++) begin
          for (j = 0; j < NUM_DENOM_REGS - 1 - i; j++) begin
            if (v[j] > v[j+1]) begin
              t = v[j];
              v[j] = v[j+1];
              v[j+1] = t;
            end
          end
        end
      end
      coins_data = ($urandom_range(0, 1) == 1) ? 16'd5 : 16'($urandom_range(0, 7));
      if ($urandom_range(0, 3) == 0) coins_data[DATA_W-1:CNT_W] = (DATA_W-CNT_W)'($urandom);
      load_config(DATA_W'(v[0]), DATA_W'(v[1]), DATA_W'(v[2]), DATA_W'(v[3]),
                  DATA_W'(v[4]), coins_data, $urandom_range(0, 3) == 0);
      // Every fourth phase runs both channels at full speed.
      send_idle = (phase % 4 != 3);
      take_idle = (phase % 4 != 3);
      for (item = 0; item < AMOUNTS_PER_PHASE; item++) begin
        r = $urandom_range(0, 99);
        if (r < 40) begin
          amount = DATA_W'($urandom_range(0, 65535));
        end else if (r < 70) begin
          amount = DATA_W'($urandom_range(0, 300));
        end else if (r < 85) begin
          // Around a multiple of one of the coins.
          amount = DATA_W'(denom_shadow[$urandom_range(0, NUM_DENOM_REGS - 1)] *
                           $urandom_range(1, 40) + $urandom_range(0, 2) - 1);
        end else if (r < 93) begin
          amount = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
        end else begin
          amount = DATA_W'(16'hFFFF - $urandom_range(0, 300));
        end
        send_amount(amount);
      end
    end
  endtask

  // Run limit.
  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence.
  initial begin
    int i;
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    amount_if.valid <= 1'b0;
    amount_if.amount <= '0;
    mismatch_count  = 0;
    send_idle       = 1'b1;
    take_idle       = 1'b1;
    for (i = 0; i < NUM_DENOM_REGS; i++) denom_shadow[i] = DENOM_RESET[i];
    coins_shadow = COINS_IN_USE_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_register_extremes();
    test_random_splits();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
